### hw/rtl/ptc_pkg.sv
// Package: shared types, constants and helpers for pressure/temperature compensation.
`default_nettype none
package ptc_pkg;
   localparam int RawWidth  = 20;
   localparam int WordWidth = 32;
   localparam int CsrWidth  = 64;
   localparam int CsrIdxWidth = 2;
   localparam int DivWidth  = 32;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TEMP_COEFFS = 2'd0,
      CSR_PRES_FIRST  = 2'd1,
      CSR_PRES_SECOND = 2'd2,
      CSR_PRES_LAST   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [15:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } coeff_type;

   // Arithmetic right shift of a 32-bit pattern.
   function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned s);
      sar = 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction
endpackage
`default_nettype wire

### hw/rtl/pressure_temperature_compensation_top.sv
// Top level: pressure/temperature compensation pipeline with calibration registers.
//
// Usage: load calibration words through the csr_ port (index 0 temperature
// coefficients, 1 and 2 pressure coefficients P1..P8, 3 P9) while idle.
// Raw readings enter as a transfer on req_ (req_valid high, req_stall low).
// Each transfer yields exactly one result transfer on rsp_ carrying the
// temperature in centidegrees, the fine temperature, pressure in pascals and
// a divide-by-zero flag (pressure then reads 0).
// Throughput: one reading pair per cycle while rsp_stall does not hold the result.
// Stages: 6 front stages, 32 divider stages - one quotient bit each, 3 back stages.
// The whole pipeline moves as one: it advances when the last stage is empty
// or the receiver takes its result; req_stall is high exactly when the final
// result is held by rsp_stall, so nothing is dropped or repeated.
// Reset clears all valid bits and the calibration registers to zero.
`default_nettype none
module pressure_temperature_compensation_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [19:0] req_raw_temperature,
   input  wire logic [19:0] req_raw_pressure,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_temperature_centideg,
   output logic [31:0]      rsp_fine_temperature,
   output logic [31:0]      rsp_pressure_pa,
   output logic             rsp_divide_by_zero
);
   import ptc_pkg::*;

   typedef struct packed {
      logic        post_double;
      logic        dz;
      logic [31:0] temp;
      logic [31:0] fine;
   } div_tag_type;

   logic [47:0] tcoef_ff;
   logic [63:0] pfirst_ff, psecond_ff;
   logic [15:0] plast_ff;
   coeff_type   coeff;

   // Calibration writes; unknown data bits above a register's width drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         tcoef_ff   <= '0;
         pfirst_ff  <= '0;
         psecond_ff <= '0;
         plast_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TEMP_COEFFS: tcoef_ff   <= csr_write_data[47:0];
            CSR_PRES_FIRST:  pfirst_ff  <= csr_write_data;
            CSR_PRES_SECOND: psecond_ff <= csr_write_data;
            CSR_PRES_LAST:   plast_ff   <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coeff.t1 = tcoef_ff[15:0];
      coeff.t2 = sx16(tcoef_ff[31:16]);
      coeff.t3 = sx16(tcoef_ff[47:32]);
      coeff.p1 = pfirst_ff[15:0];
      coeff.p2 = sx16(pfirst_ff[31:16]);
      coeff.p3 = sx16(pfirst_ff[47:32]);
      coeff.p4 = sx16(pfirst_ff[63:48]);
      coeff.p5 = sx16(psecond_ff[15:0]);
      coeff.p6 = sx16(psecond_ff[31:16]);
      coeff.p7 = sx16(psecond_ff[47:32]);
      coeff.p8 = sx16(psecond_ff[63:48]);
      coeff.p9 = sx16(plast_ff);
   end

   // Advance everything unless a finished result is held by the receiver.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic        f_valid, f_dz, f_post_double;
   logic [31:0] f_temp, f_fine, f_num, f_den;

   ptc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .coeff           (coeff),
      .in_valid        (req_valid),
      .in_ut           (req_raw_temperature),
      .in_up           (req_raw_pressure),
      .out_valid       (f_valid),
      .out_temp        (f_temp),
      .out_fine        (f_fine),
      .out_num         (f_num),
      .out_post_double (f_post_double),
      .out_den         (f_den),
      .out_dz          (f_dz)
   );

   div_tag_type d_in_tag, d_out_tag;
   logic        d_valid;
   logic [31:0] d_quo;
   always_comb begin
      d_in_tag.post_double = f_post_double;
      d_in_tag.dz          = f_dz;
      d_in_tag.temp        = f_temp;
      d_in_tag.fine        = f_fine;
   end

   ptc_div #(.TAG_TYPE(div_tag_type)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_tag    (d_in_tag),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_tag   (d_out_tag)
   );

   ptc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .coeff          (coeff),
      .in_valid       (d_valid),
      .in_quo         (d_quo),
      .in_post_double (d_out_tag.post_double),
      .in_dz          (d_out_tag.dz),
      .in_temp        (d_out_tag.temp),
      .in_fine        (d_out_tag.fine),
      .out_valid      (rsp_valid),
      .out_temp       (rsp_temperature_centideg),
      .out_fine       (rsp_fine_temperature),
      .out_pres       (rsp_pressure_pa),
      .out_dz         (rsp_divide_by_zero)
   );
endmodule
`default_nettype wire

### hw/rtl/ptc_div.sv
// Pipelined restoring divider: one quotient bit per stage, 32-bit unsigned.
`default_nettype none
module ptc_div #(
   parameter type TAG_TYPE = logic
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_num,
   input  wire logic [31:0] in_den,
   input  wire TAG_TYPE     in_tag,
   output logic             out_valid,
   output logic [31:0]      out_quo,
   output TAG_TYPE          out_tag
);
   import ptc_pkg::*;
   localparam int N = DivWidth;

   logic          vld_ff [1:N];
   logic [N-1:0]  rem_ff [1:N];
   logic [N-1:0]  quo_ff [1:N];
   logic [N-1:0]  den_ff [1:N];
   TAG_TYPE       tag_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic         vld_cur;
      logic [N-1:0] rem_cur;
      logic [N-1:0] quo_cur;
      logic [N-1:0] den_cur;
      TAG_TYPE      tag_cur;
      logic [N:0]   trial;
      logic [N:0]   diff;
      logic [N-1:0] rem_in;
      logic [N-1:0] quo_in;

      // first stage takes the operands straight from the ports
      if (k == 0) begin : g_head
         assign vld_cur = in_valid;
         assign rem_cur = '0;
         assign quo_cur = in_num;
         assign den_cur = in_den;
         assign tag_cur = in_tag;
      end else begin : g_body
         assign vld_cur = vld_ff[k];
         assign rem_cur = rem_ff[k];
         assign quo_cur = quo_ff[k];
         assign den_cur = den_ff[k];
         assign tag_cur = tag_ff[k];
      end

      always_comb begin
         trial = {rem_cur, quo_cur[N-1]};
         diff  = trial - {1'b0, den_cur};
         if (!diff[N]) begin
            rem_in = diff[N-1:0];
            quo_in = {quo_cur[N-2:0], 1'b1};
         end else begin
            rem_in = trial[N-1:0];
            quo_in = {quo_cur[N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_cur;
         end
         if (advance) begin
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
            den_ff[k+1] <= den_cur;
            tag_ff[k+1] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_quo   = quo_ff[N];
   assign out_tag   = tag_ff[N];
endmodule
`default_nettype wire

### hw/rtl/ptc_front.sv
// Front pipeline: temperature formula and pressure divisor/dividend, registered per multiply.
`default_nettype none
module ptc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire ptc_pkg::coeff_type coeff,
   input  wire logic              in_valid,
   input  wire logic [19:0]       in_ut,
   input  wire logic [19:0]       in_up,
   output logic                   out_valid,
   output logic [31:0]            out_temp,
   output logic [31:0]            out_fine,
   output logic [31:0]            out_num,
   output logic                   out_post_double,
   output logic [31:0]            out_den,
   output logic                   out_dz
);
   import ptc_pkg::*;

   // stage 1: temperature products
   logic        v1_ff;
   logic [31:0] ta_ff, dd_ff;
   logic [19:0] up1_ff;
   logic [31:0] ut32, d;
   always_comb begin
      ut32 = {12'd0, in_ut};
      d    = (ut32 >> 4) - {16'd0, coeff.t1};
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         ta_ff  <= sar(32'(((ut32 >> 3) - {15'd0, coeff.t1, 1'b0}) * coeff.t2), 11);
         dd_ff  <= 32'(d * d);
         up1_ff <= in_up;
      end
   end

   // stage 2: fine temperature
   logic        v2_ff;
   logic [31:0] fine2_ff;
   logic [19:0] up2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         fine2_ff <= ta_ff + sar(32'(sar(dd_ff, 12) * coeff.t3), 14);
         up2_ff   <= up1_ff;
      end
   end

   // stage 3: temperature, var1 and its square
   logic        v3_ff;
   logic [31:0] fine3_ff, temp3_ff, a3_ff, q3_ff;
   logic [19:0] up3_ff;
   logic [31:0] a2;
   assign a2 = sar(fine2_ff, 1) - 32'd64000;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         fine3_ff <= fine2_ff;
         temp3_ff <= sar(32'(fine2_ff * 32'd5) + 32'd128, 8);
         a3_ff    <= a2;
         q3_ff    <= 32'(sar(a2, 2) * sar(a2, 2));
         up3_ff   <= up2_ff;
      end
   end

   // stage 4: coefficient products
   logic        v4_ff;
   logic [31:0] fine4_ff, temp4_ff, b6_ff, b5_ff, c3_ff, c2_ff;
   logic [19:0] up4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         fine4_ff <= fine3_ff;
         temp4_ff <= temp3_ff;
         b6_ff    <= 32'(sar(q3_ff, 11) * coeff.p6);
         b5_ff    <= 32'(a3_ff * coeff.p5) << 1;
         c3_ff    <= 32'(coeff.p3 * sar(q3_ff, 13));
         c2_ff    <= 32'(coeff.p2 * a3_ff);
         up4_ff   <= up3_ff;
      end
   end

   // stage 5: var2 final, var1 sum
   logic        v5_ff;
   logic [31:0] fine5_ff, temp5_ff, b5s_ff, a5_ff;
   logic [19:0] up5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
      if (advance) begin
         fine5_ff <= fine4_ff;
         temp5_ff <= temp4_ff;
         b5s_ff   <= sar(b6_ff + b5_ff, 2) + (coeff.p4 << 16);
         a5_ff    <= 32'd32768 + sar(sar(c3_ff, 3) + sar(c2_ff, 1), 18);
         up5_ff   <= up4_ff;
      end
   end

   // stage 6: divisor and dividend
   logic        v6_ff;
   logic [31:0] fine6_ff, temp6_ff, den6_ff, p6_ff;
   logic [31:0] pp;
   assign pp = (32'd1048576 - {12'd0, up5_ff}) - sar(b5s_ff, 12);
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (advance) v6_ff <= v5_ff;
      if (advance) begin
         fine6_ff <= fine5_ff;
         temp6_ff <= temp5_ff;
         den6_ff  <= sar(32'(a5_ff * {16'd0, coeff.p1}), 15);
         p6_ff    <= 32'(pp * 32'd3125);
      end
   end

   assign out_valid = v6_ff;
   assign out_temp  = temp6_ff;
   assign out_fine  = fine6_ff;
   assign out_den   = den6_ff;
   assign out_dz    = (den6_ff == '0);
   // below 2^31 the doubled dividend fits; otherwise divide then double
   assign out_post_double = p6_ff[31];
   assign out_num   = p6_ff[31] ? p6_ff : {p6_ff[30:0], 1'b0};
endmodule
`default_nettype wire

### hw/rtl/ptc_back.sv
// Back pipeline: final pressure correction after the divide.
`default_nettype none
module ptc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire ptc_pkg::coeff_type coeff,
   input  wire logic               in_valid,
   input  wire logic [31:0]        in_quo,
   input  wire logic               in_post_double,
   input  wire logic               in_dz,
   input  wire logic [31:0]        in_temp,
   input  wire logic [31:0]        in_fine,
   output logic                    out_valid,
   output logic [31:0]             out_temp,
   output logic [31:0]             out_fine,
   output logic [31:0]             out_pres,
   output logic                    out_dz
);
   import ptc_pkg::*;

   logic [31:0] p0;
   assign p0 = in_post_double ? {in_quo[30:0], 1'b0} : in_quo;

   // stage 1: p and its square term
   logic        v1_ff, dz1_ff;
   logic [31:0] t1_ff, f1_ff, p1_ff, sq1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         dz1_ff <= in_dz;
         t1_ff  <= in_temp;
         f1_ff  <= in_fine;
         p1_ff  <= p0;
         sq1_ff <= 32'((p0 >> 3) * (p0 >> 3)) >> 13;
      end
   end

   // stage 2: P9 and P8 products
   logic        v2_ff, dz2_ff;
   logic [31:0] t2_ff, f2_ff, p2_ff, a2_ff, b2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         dz2_ff <= dz1_ff;
         t2_ff  <= t1_ff;
         f2_ff  <= f1_ff;
         p2_ff  <= p1_ff;
         a2_ff  <= sar(32'(coeff.p9 * sq1_ff), 12);
         b2_ff  <= sar(32'((p1_ff >> 2) * coeff.p8), 13);
      end
   end

   // stage 3: sum
   logic        v3_ff, dz3_ff;
   logic [31:0] t3_ff, f3_ff, p3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         dz3_ff <= dz2_ff;
         t3_ff  <= t2_ff;
         f3_ff  <= f2_ff;
         p3_ff  <= dz2_ff ? 32'd0 : p2_ff + sar(a2_ff + b2_ff + coeff.p7, 4);
      end
   end

   assign out_valid = v3_ff;
   assign out_temp  = t3_ff;
   assign out_fine  = f3_ff;
   assign out_pres  = p3_ff;
   assign out_dz    = dz3_ff;
endmodule
`default_nettype wire
